/* rtl/hpfa_pkg.sv */
`timescale 1ns / 1ps
package hpfa_pkg;

    localparam int PARTICLE_COUNT = 1024;
    localparam int IDX_W = 10;
    localparam int ACC_W = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SLOPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQUARED = 2'd2;

    localparam logic signed [ACC_W-1:0] MAX40 = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] MIN40 = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic                    mode;
        logic signed [31:0]      delta_x;
        logic signed [31:0]      delta_y;
        logic [IDX_W-1:0]        first_index;
        logic [IDX_W-1:0]        second_index;
    } hpfa_in_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] value_x;
        logic signed [ACC_W-1:0] value_y;
        logic                    interacted;
        logic                    zero_distance;
        logic                    saturated;
    } hpfa_out_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_CMP, ST_SQRT, ST_MAG, ST_MAGC,
        ST_DIVX, ST_DIVY, ST_MULX, ST_MULY,
        ST_RDJ, ST_WRJ, ST_RDK, ST_WRK, ST_RDR, ST_WRR, ST_OUT
    } hpfa_state_t;

    // Saturating sum of a 40-bit entry and a 41-bit force into 40 bits.
    // The force may be +2^39, so it keeps one extra bit.
    function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                input logic signed [ACC_W:0] b);
        logic signed [ACC_W:0] s;
        logic [ACC_W:0] r;
        begin
            s = {a[ACC_W-1], a} + b;
            if (s[ACC_W] != s[ACC_W-1]) begin
                r = {1'b1, s[ACC_W] ? MIN40 : MAX40};
            end else begin
                r = {1'b0, s[ACC_W-1:0]};
            end
            sat_add = r;
        end
    endfunction

endpackage

/* rtl/hpfa_divider.sv */
`timescale 1ns / 1ps
module hpfa_divider
    import hpfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);
    // Restoring division, one quotient bit per cycle.
    logic [47:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;
    logic        fits;
    logic [47:0] q_step;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg[31:0], q_reg[47]};
        fits = (trial >= {1'b0, divisor});
        q_step = {q_reg[46:0], fits};
        if (start) begin
            q_next = dividend;
            r_next = '0;
            cnt_next = 6'd48;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                r_next = trial - {1'b0, divisor};
            end else begin
                r_next = trial;
            end
            q_next = q_step;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    // The final quotient does not depend on a start in the same cycle.
    assign done = busy_reg && (cnt_reg == 6'd1);
    assign quotient = q_step;
endmodule

/* rtl/hpfa_sqrt.sv */
`timescale 1ns / 1ps
module hpfa_sqrt
    import hpfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    // Two radicand bits per cycle.
    logic [63:0] n_reg, n_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] trial, test;

    always_comb begin
        n_next = n_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[31:0], n_reg[63:62]};
        test = {root_reg, 2'b01};
        if (start) begin
            n_next = radicand;
            rem_next = '0;
            root_next = '0;
            cnt_next = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            n_next = {n_reg[61:0], 2'b00};
            if (trial >= test) begin
                rem_next = trial - test;
                root_next = {root_reg[30:0], 1'b1};
            end else begin
                rem_next = trial;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        n_reg <= n_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
    end

    assign done = busy_reg && (cnt_reg == 6'd1);
    assign root = root_next;
endmodule

/* rtl/hpfa_force_store.sv */
`timescale 1ns / 1ps
module hpfa_force_store
    import hpfa_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    rd_en,
    input  logic [IDX_W-1:0]        rd_addr,
    output logic signed [ACC_W-1:0] rd_x,
    output logic signed [ACC_W-1:0] rd_y,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_addr,
    input  logic signed [ACC_W-1:0] wr_x,
    input  logic signed [ACC_W-1:0] wr_y,
    output logic                    clearing
);
    // Both force components share one word; an epoch-free clearing pass runs after reset.
    logic [2*ACC_W-1:0] mem [PARTICLE_COUNT];
    logic [2*ACC_W-1:0] rd_reg;
    logic [IDX_W:0]     clr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (!clr_reg[IDX_W]) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!clr_reg[IDX_W]) begin
            mem[clr_reg[IDX_W-1:0]] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= {wr_x, wr_y};
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign clearing = !clr_reg[IDX_W];
    assign rd_x = rd_reg[2*ACC_W-1:ACC_W];
    assign rd_y = rd_reg[ACC_W-1:0];
endmodule

/* rtl/harmonic_pair_force_accumulator_unit.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      hpfa_in_t request
// m_        out        m_valid / m_ready      hpfa_out_t result
// cfg_      in         cfg_valid / cfg_ready  register index and data
//
// A pair request within the cutoff runs from acceptance to a valid result through the
// squares, the compare, the square root, the magnitude, the two ratio divisions, the
// component multiplies, the read-modify-write of both force entries in the force memory
// and the output register. A read request reads its entry, writes it back as zero and
// goes to the output register; a rejected or zero-separation pair skips from the compare
// to the output register. After reset a clearing pass zeroes all 1024 force entries; no
// request is accepted during it, while configuration writes are taken at any time.
// The result sits in an output register; a stalled m_ready holds the block.
module harmonic_pair_force_accumulator_unit
    import hpfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  hpfa_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output hpfa_out_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    hpfa_state_t state_reg, state_next;

    logic [30:0]        offset_reg;
    logic signed [31:0] slope_reg;
    logic [62:0]        cutoff_reg;

    hpfa_in_t           req_reg;
    logic [31:0]        ax_reg, ay_reg;
    logic [63:0]        sqx_reg, d2_reg;
    logic [31:0]        dist_reg;
    logic signed [63:0] prod_reg;
    logic [ACC_W-1:0]   am_reg;
    logic               mneg_reg;
    logic [16:0]        ratio_x_reg, ratio_y_reg;
    // One extra bit: a component can reach +2^39 when the magnitude clips low.
    logic signed [ACC_W:0] fx_reg, fy_reg;
    logic               sat_reg;
    hpfa_out_t          out_reg;
    logic               out_valid_reg;

    // Configuration is always accepted.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            slope_reg <= '0;
            cutoff_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FORCE_OFFSET: offset_reg <= cfg_data[30:0];
                CFG_FORCE_SLOPE: slope_reg <= cfg_data[31:0];
                CFG_CUTOFF_SQUARED: cutoff_reg <= cfg_data[62:0];
                default: ;
            endcase
        end
    end

    // Iterative units.
    logic        sq_start, sq_done;
    logic [31:0] sq_root;
    hpfa_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .radicand(d2_reg),
        .done(sq_done), .root(sq_root)
    );

    logic        dv_start, dv_done;
    logic [47:0] dv_dividend, dv_q;
    hpfa_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .dividend(dv_dividend),
        .divisor(dist_reg), .done(dv_done), .quotient(dv_q)
    );

    // Force memory.
    logic                    mem_rd_en, mem_wr_en, clearing;
    logic [IDX_W-1:0]        mem_rd_addr, mem_wr_addr;
    logic signed [ACC_W-1:0] mem_rd_x, mem_rd_y, mem_wr_x, mem_wr_y;
    hpfa_force_store u_store (
        .aclk(aclk), .aresetn(aresetn), .rd_en(mem_rd_en), .rd_addr(mem_rd_addr),
        .rd_x(mem_rd_x), .rd_y(mem_rd_y), .wr_en(mem_wr_en), .wr_addr(mem_wr_addr),
        .wr_x(mem_wr_x), .wr_y(mem_wr_y), .clearing(clearing)
    );

    assign s_ready = (state_reg == ST_IDLE) && !clearing && !out_valid_reg;
    logic s_fire;
    assign s_fire = s_valid && s_ready;

    logic zero_d2, in_cut;
    assign zero_d2 = (d2_reg == 64'd0);
    assign in_cut = (d2_reg <= {1'b0, cutoff_reg});

    // Index range check follows the memory depth.
    logic j_ok, k_ok;
    assign j_ok = ({22'd0, req_reg.first_index} < PARTICLE_COUNT);
    assign k_ok = ({22'd0, req_reg.second_index} < PARTICLE_COUNT);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire) state_next = s_data.mode ? ST_RDR : ST_SQX;
            ST_SQX: state_next = ST_SQY;
            ST_SQY: state_next = ST_CMP;
            ST_CMP: state_next = (in_cut && !zero_d2) ? ST_SQRT : ST_OUT;
            ST_SQRT: if (sq_done) state_next = ST_MAG;
            ST_MAG: state_next = ST_MAGC;
            ST_MAGC: state_next = ST_DIVX;
            ST_DIVX: if (dv_done) state_next = ST_DIVY;
            ST_DIVY: if (dv_done) state_next = ST_MULX;
            ST_MULX: state_next = ST_MULY;
            ST_MULY: state_next = ST_RDJ;
            ST_RDJ: state_next = ST_WRJ;
            ST_WRJ: state_next = ST_RDK;
            ST_RDK: state_next = ST_WRK;
            ST_WRK: state_next = ST_OUT;
            ST_RDR: state_next = ST_WRR;
            ST_WRR: state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Accumulator updates: add to first, then subtract from second.
    logic [ACC_W:0] sum_x, sum_y;
    always_comb begin
        if (state_reg == ST_WRK) begin
            sum_x = sat_add(mem_rd_x, -fx_reg);
            sum_y = sat_add(mem_rd_y, -fy_reg);
        end else begin
            sum_x = sat_add(mem_rd_x, fx_reg);
            sum_y = sat_add(mem_rd_y, fy_reg);
        end
    end

    // Outputs of the control.
    always_comb begin
        sq_start = 1'b0;
        dv_start = 1'b0;
        dv_dividend = {ax_reg, 16'd0};
        mem_rd_en = 1'b0;
        mem_rd_addr = req_reg.first_index;
        mem_wr_en = 1'b0;
        mem_wr_addr = req_reg.first_index;
        mem_wr_x = sum_x[ACC_W-1:0];
        mem_wr_y = sum_y[ACC_W-1:0];
        case (state_reg)
            ST_CMP: sq_start = in_cut && !zero_d2;
            ST_MAGC: dv_start = 1'b1;
            ST_DIVX: begin
                dv_start = dv_done;
                dv_dividend = {ay_reg, 16'd0};
            end
            ST_RDJ, ST_RDR: mem_rd_en = 1'b1;
            ST_WRJ: mem_wr_en = j_ok;
            ST_RDK: begin
                mem_rd_en = 1'b1;
                mem_rd_addr = req_reg.second_index;
            end
            ST_WRK: begin
                mem_wr_en = k_ok;
                mem_wr_addr = req_reg.second_index;
            end
            ST_WRR: begin
                mem_wr_en = j_ok;
                mem_wr_x = '0;
                mem_wr_y = '0;
            end
            default: ;
        endcase
    end

    // Datapath registers.
    logic signed [63:0] mag_full;
    logic signed [64:0] mag_sum;
    logic [57:0]        fmx, fmy;
    logic               neg_x, neg_y;
    assign mag_full = (prod_reg < 0) ? -((-prod_reg) >>> 16) : (prod_reg >>> 16);
    assign mag_sum = {mag_full[63], mag_full} + $signed({34'd0, offset_reg});
    assign fmx = am_reg * ratio_x_reg;
    assign fmy = am_reg * ratio_y_reg;
    assign neg_x = mneg_reg ^ req_reg.delta_x[31];
    assign neg_y = mneg_reg ^ req_reg.delta_y[31];

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg <= s_data;
            ax_reg <= s_data.delta_x[31] ? 32'(-s_data.delta_x) : s_data.delta_x;
            ay_reg <= s_data.delta_y[31] ? 32'(-s_data.delta_y) : s_data.delta_y;
            fx_reg <= '0;
            fy_reg <= '0;
            sat_reg <= 1'b0;
        end
        case (state_reg)
            ST_SQX: sqx_reg <= ax_reg * ax_reg;
            ST_SQY: d2_reg <= sqx_reg + ay_reg * ay_reg;
            ST_SQRT: if (sq_done) dist_reg <= sq_root;
            ST_MAG: prod_reg <= slope_reg * $signed({1'b0, dist_reg});
            ST_MAGC: begin
                if (mag_sum > $signed({{25{MAX40[ACC_W-1]}}, MAX40})) begin
                    am_reg <= MAX40;
                    mneg_reg <= 1'b0;
                end else if (mag_sum < $signed({{25{MIN40[ACC_W-1]}}, MIN40})) begin
                    am_reg <= MIN40;
                    mneg_reg <= 1'b1;
                end else begin
                    am_reg <= mag_sum[64] ? ACC_W'(-mag_sum) : mag_sum[ACC_W-1:0];
                    mneg_reg <= mag_sum[64];
                end
            end
            ST_DIVX: if (dv_done) ratio_x_reg <= dv_q[16:0];
            ST_DIVY: if (dv_done) ratio_y_reg <= dv_q[16:0];
            ST_MULX: fx_reg <= neg_x ? -$signed({1'b0, fmx[55:16]})
                                     : $signed({1'b0, fmx[55:16]});
            ST_MULY: fy_reg <= neg_y ? -$signed({1'b0, fmy[55:16]})
                                     : $signed({1'b0, fmy[55:16]});
            ST_WRJ: if (j_ok) sat_reg <= sat_reg | sum_x[ACC_W] | sum_y[ACC_W];
            ST_WRK: if (k_ok) sat_reg <= sat_reg | sum_x[ACC_W] | sum_y[ACC_W];
            ST_WRR: begin
                fx_reg <= j_ok ? {mem_rd_x[ACC_W-1], mem_rd_x} : '0;
                fy_reg <= j_ok ? {mem_rd_y[ACC_W-1], mem_rd_y} : '0;
            end
            default: ;
        endcase
        if (state_reg == ST_OUT) begin
            out_reg.value_x <= fx_reg[ACC_W-1:0];
            out_reg.value_y <= fy_reg[ACC_W-1:0];
            out_reg.interacted <= !req_reg.mode && in_cut && !zero_d2;
            out_reg.zero_distance <= !req_reg.mode && in_cut && zero_d2;
            out_reg.saturated <= !req_reg.mode && sat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_reg;
endmodule
